// ===== rtl/comc_pkg.sv =====
package comc_pkg;

    // operation codes of an input beat
    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SYMBOL = 3'd2,
        OP_END    = 3'd3,
        OP_ENCODE = 3'd4
    } t_op;

    // kinds of a result beat
    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_SYMBOL   = 2'd1,
        KIND_ROOT     = 2'd2,
        KIND_NOTFOUND = 2'd3
    } t_kind;

    localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*', fixed content of the root slot

endpackage

// ===== rtl/comc_in_if.sv =====
interface comc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] character;
    logic       symbol;

    modport source (output valid, output operation, output character, output symbol,
                    input ready);
    modport sink   (input valid, input operation, input character, input symbol,
                    output ready);
endinterface

// ===== rtl/comc_out_if.sv =====
interface comc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_character;
    logic       out_symbol;
    logic       last;

    modport source (output valid, output kind, output out_character, output out_symbol,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_character, input out_symbol,
                    input last, output ready);
endinterface

// ===== rtl/comc_table.sv =====
module comc_table #(
    parameter int TABLE_SLOTS = 64,
    localparam int IW = $clog2(TABLE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [TABLE_SLOTS];
    logic [7:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/comc_ctrl.sv =====
module comc_ctrl #(
    parameter int TABLE_SLOTS = 64,
    localparam int IW = $clog2(TABLE_SLOTS),
    localparam int DW = $clog2(IW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    comc_in_if.sink       i_in,
    comc_out_if.source    o_out,
    output logic          o_we,
    output logic [IW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic [IW-1:0] o_raddr,
    input  logic [7:0]    i_rdata
);
    import comc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_dec_idx, n_dec_idx;
    logic          r_dec_bad, n_dec_bad;
    logic [IW-1:0] r_scan, n_scan;
    logic [7:0]    r_ch, n_ch;
    logic          r_bad, n_bad;
    logic [IW-1:0] r_bits, n_bits;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_ov, n_ov;
    t_kind         r_kind, n_kind;
    logic [7:0]    r_och, n_och;
    logic          r_osym, n_osym;
    logic          r_olast, n_olast;

    logic          out_free;
    logic          accept;
    logic [7:0]    rd_val;
    logic          match;
    logic          at_end;
    logic [IW:0]   node;
    logic [DW-1:0] depth;
    logic [IW:0]   aligned;
    logic [IW+1:0] child;

    assign out_free   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // slot 0 is the root and always reads as '*'
    assign rd_val = (r_scan == '0) ? CH_STAR : i_rdata;
    assign match  = (rd_val == r_ch);
    assign at_end = (r_scan == r_count);

    // decode step: dot to 2i+1, dash to 2i+2
    assign child = {1'b0, r_dec_idx, 1'b1} + (IW + 2)'(i_in.symbol);

    // path bits of a slot: 1-based node number without its leading one
    assign node = {1'b0, r_scan} + (IW + 1)'(1);

    always_comb begin
        depth = '0;
        for (int i = 0; i <= IW; i++) begin
            if (node[i]) begin
                depth = DW'(i);
            end
        end
    end

    assign aligned = node << (DW'(IW) - depth);

    // sequencer and table access
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dec_idx = r_dec_idx;
        n_dec_bad = r_dec_bad;
        n_scan    = r_scan;
        n_ch      = r_ch;
        n_bad     = r_bad;
        n_bits    = r_bits;
        n_depth   = r_depth;
        n_ov      = r_ov && !o_out.ready;
        n_kind    = r_kind;
        n_och     = r_och;
        n_osym    = r_osym;
        n_olast   = r_olast;
        o_we      = 1'b0;
        o_waddr   = r_count + IW'(1);
        o_wdata   = i_in.character;
        o_raddr   = r_scan;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_op'(i_in.operation))
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_dec_idx = '0;
                            n_dec_bad = 1'b0;
                        end
                        OP_LOAD: begin
                            if (r_count != IW'(TABLE_SLOTS - 1)) begin
                                o_we    = 1'b1;
                                n_count = r_count + IW'(1);
                            end
                        end
                        OP_SYMBOL: begin
                            if (!r_dec_bad) begin
                                if (child <= {2'b00, r_count}) begin
                                    n_dec_idx = child[IW-1:0];
                                end else begin
                                    n_dec_bad = 1'b1;
                                end
                            end
                        end
                        OP_END: begin
                            o_raddr   = r_dec_idx;
                            n_scan    = r_dec_idx;
                            n_bad     = r_dec_bad;
                            n_dec_idx = '0;
                            n_dec_bad = 1'b0;
                            n_state   = ST_RDWAIT;
                        end
                        OP_ENCODE: begin
                            o_raddr = '0;
                            n_scan  = '0;
                            n_ch    = i_in.character;
                            n_state = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDWAIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = KIND_CHAR;
                    n_och   = r_bad ? CH_QUERY : rd_val;
                    n_osym  = 1'b0;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    if (r_scan == '0) begin
                        if (out_free) begin
                            n_ov    = 1'b1;
                            n_kind  = KIND_ROOT;
                            n_och   = r_ch;
                            n_osym  = 1'b0;
                            n_olast = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_bits  = aligned[IW-1:0];
                        n_depth = depth;
                        n_state = ST_EMIT;
                    end
                end else if (at_end) begin
                    if (out_free) begin
                        n_ov    = 1'b1;
                        n_kind  = KIND_NOTFOUND;
                        n_och   = CH_QUERY;
                        n_osym  = 1'b0;
                        n_olast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_raddr = r_scan + IW'(1);
                    n_scan  = r_scan + IW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = KIND_SYMBOL;
                    n_och   = r_ch;
                    n_osym  = r_bits[IW-1];
                    n_olast = (r_depth == DW'(1));
                    n_bits  = r_bits << 1;
                    n_depth = r_depth - DW'(1);
                    if (r_depth == DW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dec_idx <= '0;
            r_dec_bad <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dec_idx <= n_dec_idx;
            r_dec_bad <= n_dec_bad;
            r_ov      <= n_ov;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_ch    <= n_ch;
        r_bad   <= n_bad;
        r_bits  <= n_bits;
        r_depth <= n_depth;
        r_kind  <= n_kind;
        r_och   <= n_och;
        r_osym  <= n_osym;
        r_olast <= n_olast;
    end

    assign o_out.valid         = r_ov;
    assign o_out.kind          = r_kind;
    assign o_out.out_character = r_och;
    assign o_out.out_symbol    = r_osym;
    assign o_out.last          = r_olast;

endmodule

// ===== rtl/custom_order_morse_codec.sv =====
// clear, load and decode-symbol beats give no result
// end of letter: one table read, then ST_RDWAIT registers the result once the output stage is free
// encode: one table slot compared per cycle over slots 0..loaded count, then the
// code symbols leave ST_EMIT one beat each, held while the output stage is busy
// reset clears the loaded count, the decode walk and the output stage; the table
// contents are left as they are, slot 0 always reads as '*'
module custom_order_morse_codec #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    comc_in_if.sink    i_in,
    comc_out_if.source o_out
);

    localparam int IW = $clog2(TABLE_SLOTS);

    logic          we;
    logic [IW-1:0] waddr;
    logic [7:0]    wdata;
    logic [IW-1:0] raddr;
    logic [7:0]    rdata;

    // sequencer, decode walk and output stage
    comc_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // character table
    comc_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
